[hdl/pscm_pkg.sv]
// Package for the piecewise smoothstep curve map.
// Holds widths, register indexes and the control word types; no dependencies.
package pscm_pkg;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned POINTS_DEFAULT = 7;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 4'd0;
	localparam int unsigned QUO_W = 17;
	localparam int unsigned DEN_W = 17;

	typedef struct packed {
		logic                 bypass;
		logic signed [15:0]   direct;
		logic signed [16:0]   num;
		logic signed [16:0]   den;
		logic signed [15:0]   ya;
		logic signed [15:0]   yb;
	} seg_t;
endpackage

[hdl/pscm_if.sv]
// Valid/ready channel interfaces for the curve map.
// Has no dependencies; widths are set by parameter or fixed in the declarations.
interface pscm_stream_if #(parameter int unsigned W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pscm_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[hdl/pscm_segment.sv]
// Segment selection stage: compares the sample with every breakpoint in use.
// Depends on pscm_pkg.
module pscm_segment #(parameter int unsigned MAX_POINTS = 7) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vin,
	input  logic signed [15:0]           v,
	input  logic [2:0]                   count,
	input  logic [MAX_POINTS-1:0][31:0]  pts,
	output logic                         vout,
	output pscm_pkg::seg_t               seg_s1
);
	import pscm_pkg::*;
	localparam int unsigned IW = $clog2(MAX_POINTS);
	logic [2:0] n;
	logic [IW-1:0] bi, ai, li;
	logic signed [15:0] xa, xb, xl, x0;
	seg_t nxt;
	always_comb begin
		n = (count > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : count;
		li = (n >= 3'd1) ? IW'(n - 3'd1) : '0;
		bi = li;
		for (int i = MAX_POINTS - 1; i >= 1; i--) begin
			if (i < n && $signed(pts[i][31:16]) > v) bi = IW'(i);
		end
		ai = (bi == '0) ? '0 : bi - IW'(1);
		xa = $signed(pts[ai][31:16]);
		xb = $signed(pts[bi][31:16]);
		xl = $signed(pts[li][31:16]);
		x0 = $signed(pts[0][31:16]);
		nxt.bypass = 1'b1;
		nxt.num = 17'(v) - 17'(xa);
		nxt.den = 17'(xb) - 17'(xa);
		nxt.ya = $signed(pts[ai][15:0]);
		nxt.yb = $signed(pts[bi][15:0]);
		if (n < 3'd2) nxt.direct = v;
		else if (v <= x0) nxt.direct = $signed(pts[0][15:0]);
		else if (v >= xl) nxt.direct = $signed(pts[li][15:0]);
		else if (xa == xb) nxt.direct = nxt.yb;
		else begin
			nxt.direct = nxt.yb;
			nxt.bypass = 1'b0;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) seg_s1 <= nxt;
	end
endmodule

[hdl/pscm_divider.sv]
// Pipelined restoring divider producing the clamped Q0.16 position.
// Carries the segment word alongside; depends on pscm_pkg.
module pscm_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  pscm_pkg::seg_t    seg,
	output logic              vout,
	output pscm_pkg::seg_t    seg_o,
	output logic [15:0]       t_o
);
	import pscm_pkg::*;
	localparam int unsigned ST = 34;
	localparam int unsigned BPS = 3;
	localparam int unsigned NS = (ST + BPS - 1) / BPS;
	logic                   vq [NS+1];
	seg_t                   sq [NS+1];
	logic [33:0]            nq [NS+1];
	logic [16:0]            dq [NS+1];
	logic [16:0]            rq [NS+1];
	logic [33:0]            qq [NS+1];
	logic                   negq [NS+1];
	logic                   an, ad;
	always_comb begin
		an = seg.num[16];
		ad = seg.den[16];
		vq[0] = vin;
		sq[0] = seg;
		nq[0] = {1'b0, (an ? 17'(-seg.num) : 17'(seg.num)), 16'd0};
		dq[0] = ad ? 17'(-seg.den) : 17'(seg.den);
		rq[0] = '0;
		qq[0] = '0;
		negq[0] = an ^ ad;
	end
	for (genvar g = 0; g < NS; g++) begin : g_st
		logic [17:0] r;
		logic [33:0] q;
		logic [33:0] nn;
		always_comb begin
			r = {1'b0, rq[g]};
			q = qq[g];
			nn = nq[g];
			for (int k = 0; k < BPS; k++) begin
				if (g * BPS + k < ST) begin
					r = {r[16:0], nn[33]};
					nn = {nn[32:0], 1'b0};
					if (r >= {1'b0, dq[g]}) begin
						r = r - {1'b0, dq[g]};
						q = {q[32:0], 1'b1};
					end else q = {q[32:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vq[g+1] <= 1'b0;
			else if (en) vq[g+1] <= vq[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq[g+1] <= sq[g];
				nq[g+1] <= nn;
				dq[g+1] <= dq[g];
				rq[g+1] <= r[16:0];
				qq[g+1] <= q;
				negq[g+1] <= negq[g];
			end
		end
	end
	// A positive quotient of 2^16 or more saturates to the top of the Q0.16 range; a negative one gives zero.
	logic [33:0] qmag;
	assign qmag = qq[NS];
	assign vout = vq[NS];
	assign seg_o = sq[NS];
	assign t_o = (negq[NS] || qmag == '0) ? 16'd0 :
		((|qmag[33:16]) ? 16'hFFFF : qmag[15:0]);
endmodule

[hdl/pscm_blend.sv]
// Smoothstep and blend stages: t*t, then times (3-2t), then scaled difference.
// Depends on pscm_pkg.
module pscm_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vin,
	input  pscm_pkg::seg_t   seg,
	input  logic [15:0]      t,
	output logic             vout,
	output logic [15:0]      res
);
	import pscm_pkg::*;
	logic [3:0]         v_q;
	seg_t               seg_s1, seg_s2, seg_s3;
	logic [31:0]        tt_s1;
	logic [17:0]        w_s1;
	logic [15:0]        s_s2;
	logic signed [16:0] diff_s3;
	logic [15:0]        s_s3;
	logic signed [34:0] prod_s4;
	seg_t               seg_s4;
	logic [49:0]        full;
	logic signed [34:0] dlt;
	assign full = tt_s1 * w_s1;
	assign dlt = (prod_s4 < 0) ? -((-prod_s4) >>> 16) : (prod_s4 >>> 16);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[2:0], vin};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= seg;
			tt_s1 <= t * t;
			w_s1 <= 18'd196608 - {1'b0, t, 1'b0};
			seg_s2 <= seg_s1;
			s_s2 <= full[47:32];
			seg_s3 <= seg_s2;
			s_s3 <= s_s2;
			diff_s3 <= 17'(seg_s2.yb) - 17'(seg_s2.ya);
			seg_s4 <= seg_s3;
			prod_s4 <= diff_s3 * $signed({1'b0, s_s3});
		end
	end
	assign vout = v_q[3];
	assign res = seg_s4.bypass ? seg_s4.direct : 16'(seg_s4.ya + 16'(dlt));
endmodule

[hdl/piecewise_smoothstep_curve_map.sv]
// Top level of the piecewise smoothstep curve map.
// Depends on pscm_pkg, pscm_if, pscm_segment, pscm_divider and pscm_blend.
//
// Samples arrive on sample_in and mapped values leave on mapped_value, both
// valid/ready streams carrying one signed Q1.15 word per handshake.
// Breakpoints and the point count are written through cfg; index 0 is the
// count and indexes 1 to 7 are the packed points. Writes are always taken.
// One word is accepted every cycle unless the output stalls. The pipeline
// holds segment selection, the three-bit-a-step divider, and the smoothstep
// and blend multipliers. Reset clears cfg and empties the pipeline.
// When the receiver stalls, the whole pipeline and the output register hold;
// input is taken while the pipeline has a free slot at its output.
module piecewise_smoothstep_curve_map #(
	parameter int unsigned MAX_POINTS = pscm_pkg::POINTS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	pscm_stream_if.sink   sample_in,
	pscm_stream_if.source mapped_value,
	pscm_cfg_if.sink      cfg
);
	import pscm_pkg::*;
	logic [2:0]                  count_q;
	logic [MAX_POINTS-1:0][31:0] pts_q;
	logic                        en, v1, v2, v3;
	seg_t                        seg1, seg2;
	logic [15:0]                 t2, res;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pts_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_COUNT) count_q <= cfg.data[2:0];
			for (int i = 0; i < MAX_POINTS; i++)
				if (32'(cfg.index) == 32'(i + 1)) pts_q[i] <= cfg.data;
		end
	end
	assign en = !mapped_value.valid || mapped_value.ready;
	assign sample_in.ready = en;
	pscm_segment #(.MAX_POINTS(MAX_POINTS)) u_seg (
		.clk, .arst_n, .en, .vin(sample_in.valid), .v($signed(sample_in.data)),
		.count(count_q), .pts(pts_q), .vout(v1), .seg_s1(seg1));
	pscm_divider u_div (
		.clk, .arst_n, .en, .vin(v1), .seg(seg1), .vout(v2), .seg_o(seg2), .t_o(t2));
	pscm_blend u_bl (
		.clk, .arst_n, .en, .vin(v2), .seg(seg2), .t(t2), .vout(v3), .res(res));
	assign mapped_value.valid = v3;
	assign mapped_value.data = res;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mapped_value.valid && !mapped_value.ready |=> mapped_value.valid)
		else $error("result lost under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sample_in.ready == (!mapped_value.valid || mapped_value.ready))
		else $error("input ready does not follow output stall");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		mapped_value.valid && !mapped_value.ready |=> $stable(mapped_value.data))
		else $error("result changed under stall");
endmodule
